@@ hdl/c2p_pkg.sv @@
package c2p_pkg;

    // Sizes of the stored state.
    localparam int unsigned PALETTES        = 14;
    localparam int unsigned PALETTE_ENTRIES = 256;
    localparam int unsigned BYTES_PER_PLANE = 16384;
    localparam int unsigned TABLE_SIZE      = PALETTES * PALETTE_ENTRIES;
    localparam int unsigned PLANES          = 4;
    localparam int unsigned PIXELS          = 4;
    localparam int unsigned QUEUE_DEPTH     = 4;

    // Field widths fixed by the interface.
    localparam int unsigned OPERATION_W = 1;
    localparam int unsigned INDEX_W     = 12;
    localparam int unsigned OFFSET_W    = 14;
    localparam int unsigned PIXEL_W     = 8;
    localparam int unsigned PAL_W       = 4;
    localparam int unsigned PLANE_W     = 2;

    // Address widths derived from the store depths.
    localparam int unsigned TABLE_AW  = $clog2(TABLE_SIZE);
    localparam int unsigned SHADOW_AW = (BYTES_PER_PLANE > 1) ? $clog2(BYTES_PER_PLANE) : 1;
    localparam int unsigned OFFSET_XW = 17;
    localparam int unsigned QPTR_W    = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W    = $clog2(QUEUE_DEPTH + 1);

    // Operation codes.
    localparam logic [OPERATION_W-1:0] OP_LOAD    = 1'b0;
    localparam logic [OPERATION_W-1:0] OP_CONVERT = 1'b1;

    typedef logic [PLANES-1:0][7:0] t_row;
    typedef logic [PIXELS-1:0][7:0] t_colours;

    // One converted group waiting to be written out.
    typedef struct packed {
        logic [OFFSET_W-1:0] offset;
        t_row                row;
        logic [PLANES-1:0]   mask;
    } t_job;

    // Bit p of each colour's high and low nibble, pixel 0 high nibble in the MSB.
    function automatic t_row pack_planes(input t_colours cols);
        t_row r;
        r = '0;
        for (int p = 0; p < PLANES; p++) begin
            for (int k = 0; k < PIXELS; k++) begin
                r[p][7 - 2 * k] = cols[k][4 + p];
                r[p][6 - 2 * k] = cols[k][p];
            end
        end
        return r;
    endfunction

endpackage

@@ hdl/c2p_front.sv @@
module c2p_front (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic [c2p_pkg::PAL_W-1:0]            i_palette_select,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic [c2p_pkg::OPERATION_W-1:0]      i_operation,
    input  logic [c2p_pkg::INDEX_W-1:0]          i_table_index,
    input  logic [7:0]                           i_table_value,
    input  logic [c2p_pkg::OFFSET_W-1:0]         i_byte_offset,
    input  c2p_pkg::t_colours                    i_pixels,
    output logic                                 o_push,
    output c2p_pkg::t_job                        o_job,
    input  logic                                 i_full
);

    logic                                w_accept;
    logic                                w_load;
    logic                                w_conv;
    logic                                w_s1_adv;
    logic [c2p_pkg::PAL_W-1:0]           w_pal;
    logic [c2p_pkg::OFFSET_XW-1:0]       w_off_x;
    logic [c2p_pkg::OFFSET_XW-1:0]       w_s1_off_x;
    c2p_pkg::t_row                       w_packed;
    c2p_pkg::t_row                       w_old;
    logic [c2p_pkg::PLANES-1:0]          w_mask;
    logic                                w_sh_we;
    logic [c2p_pkg::SHADOW_AW-1:0]       w_sh_waddr;
    c2p_pkg::t_row                       w_sh_wdata;

    logic                                r_clearing;
    logic [c2p_pkg::SHADOW_AW-1:0]       r_clr_cnt;
    logic                                r_s1_valid;
    logic [c2p_pkg::OFFSET_W-1:0]        r_s1_off;
    c2p_pkg::t_colours                   r_cols;
    c2p_pkg::t_row                       r_sh_row;
    logic                                r_fwd_valid;
    logic [c2p_pkg::OFFSET_W-1:0]        r_fwd_off;
    c2p_pkg::t_row                       r_fwd_row;

    c2p_pkg::t_row                       shadow_mem [c2p_pkg::BYTES_PER_PLANE];

    assign o_stall  = r_clearing || (r_s1_valid && i_full);
    assign w_accept = i_valid && !o_stall;
    assign w_off_x  = c2p_pkg::OFFSET_XW'(i_byte_offset);
    assign w_load   = w_accept && (i_operation == c2p_pkg::OP_LOAD) &&
                      ({1'b0, i_table_index} < (c2p_pkg::INDEX_W + 1)'(c2p_pkg::TABLE_SIZE));
    assign w_conv   = w_accept && (i_operation == c2p_pkg::OP_CONVERT) &&
                      (w_off_x < c2p_pkg::OFFSET_XW'(c2p_pkg::BYTES_PER_PLANE));
    assign w_s1_adv = r_s1_valid && !i_full;

    // Out-of-range selections use the last palette.
    assign w_pal = ({1'b0, i_palette_select} >= (c2p_pkg::PAL_W + 1)'(c2p_pkg::PALETTES)) ?
                   c2p_pkg::PAL_W'(c2p_pkg::PALETTES - 1) : i_palette_select;

    // One copy of the colour table per pixel, so all four lookups happen together.
    for (genvar k = 0; k < c2p_pkg::PIXELS; k++) begin : g_table
        logic [7:0]                    table_mem [c2p_pkg::TABLE_SIZE];
        logic [c2p_pkg::INDEX_W-1:0]   w_raddr;

        assign w_raddr = {w_pal, i_pixels[k]};

        always_ff @(posedge i_clk) begin
            if (w_load) begin
                table_mem[i_table_index[c2p_pkg::TABLE_AW-1:0]] <= i_table_value;
            end
            if (w_conv) begin
                r_cols[k] <= table_mem[w_raddr[c2p_pkg::TABLE_AW-1:0]];
            end
        end
    end

    assign w_packed = c2p_pkg::pack_planes(r_cols);

    // The row written at the edge this item entered was read stale; take it from the bypass.
    assign w_old  = (r_fwd_valid && (r_fwd_off == r_s1_off)) ? r_fwd_row : r_sh_row;

    for (genvar p = 0; p < c2p_pkg::PLANES; p++) begin : g_cmp
        assign w_mask[p] = (w_packed[p] != w_old[p]);
    end

    assign w_s1_off_x = c2p_pkg::OFFSET_XW'(r_s1_off);
    assign w_sh_we    = r_clearing || w_s1_adv;
    assign w_sh_waddr = r_clearing ? r_clr_cnt : w_s1_off_x[c2p_pkg::SHADOW_AW-1:0];
    assign w_sh_wdata = r_clearing ? '0 : w_packed;

    always_ff @(posedge i_clk) begin
        if (w_sh_we) begin
            shadow_mem[w_sh_waddr] <= w_sh_wdata;
        end
        if (w_conv) begin
            r_sh_row <= shadow_mem[w_off_x[c2p_pkg::SHADOW_AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing  <= 1'b1;
            r_clr_cnt   <= '0;
            r_s1_valid  <= 1'b0;
            r_fwd_valid <= 1'b0;
        end else begin
            if (r_clearing) begin
                r_clr_cnt <= r_clr_cnt + 1'b1;
                if (r_clr_cnt == c2p_pkg::SHADOW_AW'(c2p_pkg::BYTES_PER_PLANE - 1)) begin
                    r_clearing <= 1'b0;
                end
            end
            if (w_conv) begin
                r_s1_valid  <= 1'b1;
                r_fwd_valid <= w_s1_adv;
            end else if (w_s1_adv) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_conv) begin
            r_s1_off  <= i_byte_offset;
            r_fwd_off <= r_s1_off;
            r_fwd_row <= w_packed;
        end
    end

    assign o_push        = w_s1_adv && (w_mask != '0);
    assign o_job.offset  = r_s1_off;
    assign o_job.row     = w_packed;
    assign o_job.mask    = w_mask;

endmodule

@@ hdl/c2p_queue.sv @@
module c2p_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  c2p_pkg::t_job  i_job,
    output logic           o_full,
    output logic           o_valid,
    output c2p_pkg::t_job  o_job,
    input  logic           i_pop
);

    c2p_pkg::t_job                r_slot [c2p_pkg::QUEUE_DEPTH];
    logic [c2p_pkg::QPTR_W-1:0]   r_wptr;
    logic [c2p_pkg::QPTR_W-1:0]   r_rptr;
    logic [c2p_pkg::QCNT_W-1:0]   r_count;
    logic [c2p_pkg::QCNT_W-1:0]   n_count;

    assign o_full  = (r_count == c2p_pkg::QCNT_W'(c2p_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_slot[r_rptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wptr <= (r_wptr == c2p_pkg::QPTR_W'(c2p_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == c2p_pkg::QPTR_W'(c2p_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : r_rptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wptr] <= i_job;
        end
    end

endmodule

@@ hdl/c2p_back.sv @@
module c2p_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_job_valid,
    input  c2p_pkg::t_job                     i_job,
    output logic                              o_pop,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [c2p_pkg::PLANE_W-1:0]       o_plane,
    output logic [c2p_pkg::OFFSET_W-1:0]      o_write_offset,
    output logic [7:0]                        o_plane_byte,
    output logic                              o_last_of_run
);

    logic                                r_busy;
    logic [c2p_pkg::PLANES-1:0]          r_rem;
    logic                                r_out_valid;
    logic [c2p_pkg::PLANE_W-1:0]         r_plane;
    logic [c2p_pkg::OFFSET_W-1:0]        r_offset;
    logic [7:0]                          r_byte;
    logic                                r_last;

    logic [c2p_pkg::PLANES-1:0]          w_cur;
    logic [c2p_pkg::PLANES-1:0]          w_rest;
    logic [c2p_pkg::PLANE_W-1:0]         w_sel;
    logic                                w_load;

    assign w_cur  = r_busy ? r_rem : i_job.mask;
    assign w_load = i_job_valid && (!r_out_valid || !i_stall);

    // Planes leave highest first.
    always_comb begin
        priority if (w_cur[3]) begin
            w_sel = 2'd3;
        end else if (w_cur[2]) begin
            w_sel = 2'd2;
        end else if (w_cur[1]) begin
            w_sel = 2'd1;
        end else begin
            w_sel = 2'd0;
        end
    end

    always_comb begin
        w_rest        = w_cur;
        w_rest[w_sel] = 1'b0;
    end

    assign o_pop = w_load && (w_rest == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_out_valid <= 1'b1;
                r_busy      <= (w_rest != '0);
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_rem    <= w_rest;
            r_plane  <= w_sel;
            r_offset <= i_job.offset;
            r_byte   <= i_job.row[w_sel];
            r_last   <= (w_rest == '0);
        end
    end

    assign o_valid        = r_out_valid;
    assign o_plane        = r_plane;
    assign o_write_offset = r_offset;
    assign o_plane_byte   = r_byte;
    assign o_last_of_run  = r_last;

endmodule

@@ hdl/chunky_to_planar_dirty_writer_core.sv @@
// Channel   Direction  Handshake                   Payload
// input     in         i_in_valid / o_in_stall     i_operation, i_table_index, i_table_value,
//                                                  i_byte_offset, i_pixel_zero..i_pixel_three
// result    out        o_out_valid / i_out_stall   o_plane, o_write_offset, o_plane_byte,
//                                                  o_last_of_run
// config    in         i_cfg_wr_en                 i_cfg_wr_data (palette select)
//
// One input transfer (load or conversion) is taken per cycle unless the plane queue is full
// while the lookup stage holds a group; a conversion is registered in the lookup stage
// before it enters the queue. Results leave one transfer per cycle unless i_out_stall is
// high, so a group costs one transfer per changed plane byte (zero to four), and the single
// result port sets the sustained rate. After reset the shadow is cleared one row per cycle,
// all BYTES_PER_PLANE (16384) rows, with o_in_stall high; config writes are taken throughout.
module chunky_to_planar_dirty_writer_core (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_wr_en,
    input  logic [c2p_pkg::PAL_W-1:0]            i_cfg_wr_data,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic [c2p_pkg::OPERATION_W-1:0]      i_operation,
    input  logic [c2p_pkg::INDEX_W-1:0]          i_table_index,
    input  logic [7:0]                           i_table_value,
    input  logic [c2p_pkg::OFFSET_W-1:0]         i_byte_offset,
    input  logic [c2p_pkg::PIXEL_W-1:0]          i_pixel_zero,
    input  logic [c2p_pkg::PIXEL_W-1:0]          i_pixel_one,
    input  logic [c2p_pkg::PIXEL_W-1:0]          i_pixel_two,
    input  logic [c2p_pkg::PIXEL_W-1:0]          i_pixel_three,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic [c2p_pkg::PLANE_W-1:0]          o_plane,
    output logic [c2p_pkg::OFFSET_W-1:0]         o_write_offset,
    output logic [7:0]                           o_plane_byte,
    output logic                                 o_last_of_run
);

    // Write the palette select register only while the block is idle; no check enforces it.
    logic [c2p_pkg::PAL_W-1:0]   r_palette_select;

    c2p_pkg::t_colours           w_pixels;
    logic                        w_push;
    c2p_pkg::t_job               w_push_job;
    logic                        w_q_full;
    logic                        w_q_valid;
    c2p_pkg::t_job               w_q_job;
    logic                        w_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_palette_select <= '0;
        end else if (i_cfg_wr_en) begin
            r_palette_select <= i_cfg_wr_data;
        end
    end

    // Pixel zero sits in element zero, which the packer places in the top bits.
    assign w_pixels[0] = i_pixel_zero;
    assign w_pixels[1] = i_pixel_one;
    assign w_pixels[2] = i_pixel_two;
    assign w_pixels[3] = i_pixel_three;

    // The front end does table loads, palette lookups, packing and the dirty compare
    // against the shadow, and writes the new row back to the shadow.
    c2p_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_palette_select (r_palette_select),
        .i_valid          (i_in_valid),
        .o_stall          (o_in_stall),
        .i_operation      (i_operation),
        .i_table_index    (i_table_index),
        .i_table_value    (i_table_value),
        .i_byte_offset    (i_byte_offset),
        .i_pixels         (w_pixels),
        .o_push           (w_push),
        .o_job            (w_push_job),
        .i_full           (w_q_full)
    );

    // Groups with at least one changed plane wait here for the result port.
    c2p_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_push_job),
        .o_full  (w_q_full),
        .o_valid (w_q_valid),
        .o_job   (w_q_job),
        .i_pop   (w_pop)
    );

    // The back end sends the changed planes of each group, highest plane first.
    c2p_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_job_valid    (w_q_valid),
        .i_job          (w_q_job),
        .o_pop          (w_pop),
        .o_valid        (o_out_valid),
        .i_stall        (i_out_stall),
        .o_plane        (o_plane),
        .o_write_offset (o_write_offset),
        .o_plane_byte   (o_plane_byte),
        .o_last_of_run  (o_last_of_run)
    );

    // The front end must never push into a full queue.
    a_no_overflow : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_q_full)
        else $error("plane queue overflow");

    // The back end only retires a queue entry that exists.
    a_no_underflow : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_q_valid)
        else $error("plane queue underflow");

    // Within one group, the next plane follows at once and with a lower plane number.
    a_run_continues : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && !o_last_of_run) |=>
        (o_out_valid && (o_plane < $past(o_plane))))
        else $error("group of plane writes broken");

endmodule

@@ dv/chunky_to_planar_dirty_writer_checker.sv @@
module chunky_to_planar_dirty_writer_checker
    import c2p_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_wr_en,
    input  logic [PAL_W-1:0]       i_cfg_wr_data,
    input  logic                   i_in_valid,
    input  logic                   i_in_stall,
    input  logic [OPERATION_W-1:0] i_operation,
    input  logic [INDEX_W-1:0]     i_table_index,
    input  logic [7:0]             i_table_value,
    input  logic [OFFSET_W-1:0]    i_byte_offset,
    input  logic [PIXEL_W-1:0]     i_pixel_zero,
    input  logic [PIXEL_W-1:0]     i_pixel_one,
    input  logic [PIXEL_W-1:0]     i_pixel_two,
    input  logic [PIXEL_W-1:0]     i_pixel_three,
    input  logic                   i_out_valid,
    input  logic                   i_out_stall,
    input  logic [PLANE_W-1:0]     i_plane,
    input  logic [OFFSET_W-1:0]    i_write_offset,
    input  logic [7:0]             i_plane_byte,
    input  logic                   i_last_of_run,
    output int                     o_fail_count,
    output int                     o_outstanding,
    output int                     o_table_loads,
    output int                     o_pixel_groups,
    output int                     o_writes_checked
);

    typedef struct packed {
        logic [PLANE_W-1:0]  plane;
        logic [OFFSET_W-1:0] offset;
        logic [7:0]          value;
        logic                last;
    } t_plane_write;

    logic [7:0]   colour_mem [TABLE_SIZE];
    logic [7:0]   shadow_mem [PLANES * BYTES_PER_PLANE];
    logic [PAL_W-1:0] palette_reg;
    t_plane_write plane_writes_due [$];

    int mismatches;
    int due_count;
    int loads_seen;
    int groups_seen;
    int writes_seen;

    assign o_fail_count     = mismatches;
    assign o_outstanding    = due_count;
    assign o_table_loads    = loads_seen;
    assign o_pixel_groups   = groups_seen;
    assign o_writes_checked = writes_seen;

    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("MISMATCH at %0t: %s", $time, msg);
    endtask

    // Looks the four pixels up, packs one byte per plane and queues the planes
    // whose shadow byte differs, highest plane first.
    task automatic predict_plane_writes();
        logic [PAL_W-1:0] pal;
        logic [7:0]       colour [PIXELS];
        logic [7:0]       plane_bits [PLANES];
        logic             dirty [PLANES];
        int               base;
        int               last_plane;
        t_plane_write     w;
        groups_seen++;
        if (int'(i_byte_offset) >= BYTES_PER_PLANE) begin
            return;
        end
        pal = (int'(palette_reg) >= PALETTES) ? PAL_W'(PALETTES - 1) : palette_reg;
        base = int'(pal) * PALETTE_ENTRIES;
        colour[0] = colour_mem[base + int'(i_pixel_zero)];
        colour[1] = colour_mem[base + int'(i_pixel_one)];
        colour[2] = colour_mem[base + int'(i_pixel_two)];
        colour[3] = colour_mem[base + int'(i_pixel_three)];
        last_plane = -1;
        for (int p = PLANES - 1; p >= 0; p--) begin
            plane_bits[p] = {colour[0][4 + p], colour[0][p], colour[1][4 + p], colour[1][p],
                             colour[2][4 + p], colour[2][p], colour[3][4 + p], colour[3][p]};
            dirty[p] = plane_bits[p] != shadow_mem[p * BYTES_PER_PLANE + int'(i_byte_offset)];
            if (dirty[p]) begin
                last_plane = p;
            end
        end
        for (int p = PLANES - 1; p >= 0; p--) begin
            if (dirty[p]) begin
                shadow_mem[p * BYTES_PER_PLANE + int'(i_byte_offset)] = plane_bits[p];
                w.plane  = PLANE_W'(p);
                w.offset = i_byte_offset;
                w.value  = plane_bits[p];
                w.last   = (p == last_plane);
                plane_writes_due.push_back(w);
            end
        end
    endtask

    task automatic check_plane_write();
        t_plane_write want;
        writes_seen++;
        if (plane_writes_due.size() == 0) begin
            report_mismatch($sformatf("unexpected write: plane %0d offset %0d byte %02h last %0b",
                                      i_plane, i_write_offset, i_plane_byte, i_last_of_run));
            return;
        end
        want = plane_writes_due.pop_front();
        if (i_plane !== want.plane || i_write_offset !== want.offset ||
            i_plane_byte !== want.value || i_last_of_run !== want.last) begin
            report_mismatch($sformatf(
                "got plane %0d offset %0d byte %02h last %0b, want %0d %0d %02h %0b",
                i_plane, i_write_offset, i_plane_byte, i_last_of_run,
                want.plane, want.offset, want.value, want.last));
        end
    endtask

    // A result never leaves in the cycle its group is taken, so checking the
    // output before predicting the input keeps the queue order right.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            plane_writes_due.delete();
            for (int a = 0; a < PLANES * BYTES_PER_PLANE; a++) begin
                shadow_mem[a] = 8'h00;
            end
            palette_reg = '0;
            mismatches  = 0;
            loads_seen  = 0;
            groups_seen = 0;
            writes_seen = 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                check_plane_write();
            end
            if (i_in_valid && !i_in_stall) begin
                if (i_operation == OP_LOAD) begin
                    loads_seen++;
                    if (int'(i_table_index) < TABLE_SIZE) begin
                        colour_mem[i_table_index] = i_table_value;
                    end
                end else begin
                    predict_plane_writes();
                end
            end
            if (i_cfg_wr_en) begin
                palette_reg = i_cfg_wr_data;
            end
        end
        due_count = plane_writes_due.size();
    end

endmodule

@@ dv/chunky_to_planar_dirty_writer_core_tb.sv @@
// Top of the converter testbench. It only produces stimulus and gives the
// verdict; the checker module next to the block watches both channels,
// predicts every plane write and counts mismatches.
module chunky_to_planar_dirty_writer_core_tb;

    import c2p_pkg::*;

    // Cycles to wait after the last expected write before a palette change
    // or the verdict. A group passes the lookup stage register before it enters the plane
    // queue, and a group that changes nothing leaves no trace to wait on.
    localparam int SETTLE_CYCLES = 10;
    // Upper bound on the wait for outstanding writes while draining.
    localparam int DRAIN_LIMIT = 20000;
    localparam int RANDOM_PER_PHASE = 52;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   i_cfg_wr_en;
    logic [PAL_W-1:0]       i_cfg_wr_data;
    logic                   i_in_valid;
    logic                   o_in_stall;
    logic [OPERATION_W-1:0] i_operation;
    logic [INDEX_W-1:0]     i_table_index;
    logic [7:0]             i_table_value;
    logic [OFFSET_W-1:0]    i_byte_offset;
    logic [PIXEL_W-1:0]     i_pixel_zero;
    logic [PIXEL_W-1:0]     i_pixel_one;
    logic [PIXEL_W-1:0]     i_pixel_two;
    logic [PIXEL_W-1:0]     i_pixel_three;
    logic                   o_out_valid;
    logic                   i_out_stall = 1'b0;
    logic [PLANE_W-1:0]     o_plane;
    logic [OFFSET_W-1:0]    o_write_offset;
    logic [7:0]             o_plane_byte;
    logic                   o_last_of_run;

    int fail_count;
    int outstanding;
    int table_loads;
    int pixel_groups;
    int writes_checked;

    // Which table entries hold a known value. A group may only name entries
    // of the palette in use that were loaded, since unwritten entries have
    // no defined contents.
    bit   entry_loaded [TABLE_SIZE];
    int   usable_entries [$];
    int   active_pal;
    int   burst_left;
    int   palette_writes;

    // The plan of palette settings after the directed part. Fifteen and
    // fourteen are out of range and must behave as thirteen, the top palette.
    logic [PAL_W-1:0] palette_plan [5] = '{4'd13, 4'd15, 4'd7, 4'd14, 4'd0};

    // Receiver stall pattern state.
    int         stall_mode = 0;
    int         stall_span = 0;
    logic [3:0] stall_phase = '0;

    chunky_to_planar_dirty_writer_core DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_operation    (i_operation),
        .i_table_index  (i_table_index),
        .i_table_value  (i_table_value),
        .i_byte_offset  (i_byte_offset),
        .i_pixel_zero   (i_pixel_zero),
        .i_pixel_one    (i_pixel_one),
        .i_pixel_two    (i_pixel_two),
        .i_pixel_three  (i_pixel_three),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_plane        (o_plane),
        .o_write_offset (o_write_offset),
        .o_plane_byte   (o_plane_byte),
        .o_last_of_run  (o_last_of_run)
    );

    chunky_to_planar_dirty_writer_checker write_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_wr_data    (i_cfg_wr_data),
        .i_in_valid       (i_in_valid),
        .i_in_stall       (o_in_stall),
        .i_operation      (i_operation),
        .i_table_index    (i_table_index),
        .i_table_value    (i_table_value),
        .i_byte_offset    (i_byte_offset),
        .i_pixel_zero     (i_pixel_zero),
        .i_pixel_one      (i_pixel_one),
        .i_pixel_two      (i_pixel_two),
        .i_pixel_three    (i_pixel_three),
        .i_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .i_plane          (o_plane),
        .i_write_offset   (o_write_offset),
        .i_plane_byte     (o_plane_byte),
        .i_last_of_run    (o_last_of_run),
        .o_fail_count     (fail_count),
        .o_outstanding    (outstanding),
        .o_table_loads    (table_loads),
        .o_pixel_groups   (pixel_groups),
        .o_writes_checked (writes_checked)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // The result side runs its own stall pattern, picked anew whenever its span runs out:
    // no stall at all, one cycle in four, a coin toss per cycle, or long stretches of
    // stall that back the plane queue up into the input.
    always @(negedge i_clk) begin
        stall_phase <= stall_phase + 4'd1;
        if (stall_span == 0) begin
            stall_mode <= $urandom_range(0, 3);
            stall_span <= $urandom_range(16, 96);
        end else begin
            stall_span <= stall_span - 1;
        end
        case (stall_mode)
            0: begin
                i_out_stall <= 1'b0;
            end
            1: begin
                i_out_stall <= (stall_phase[1:0] == 2'd3);
            end
            2: begin
                i_out_stall <= 1'($urandom_range(0, 1));
            end
            default: begin
                i_out_stall <= (stall_phase < 4'd11);
            end
        endcase
    end

    // Hands one transfer to the block. Transfers come in bursts of random
    // length; between bursts valid drops for a random gap, and about one
    // burst in four follows the previous one with no gap at all. Valid is
    // only raised at a falling edge and held until a rising edge sees the
    // stall low, so a stalled payload never moves.
    task automatic push_transfer(input logic [OPERATION_W-1:0] op,
                                 input logic [INDEX_W-1:0] tidx,
                                 input logic [7:0] tval,
                                 input logic [OFFSET_W-1:0] off,
                                 input logic [7:0] p0, input logic [7:0] p1,
                                 input logic [7:0] p2, input logic [7:0] p3);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            repeat (gap) begin
                @(negedge i_clk);
                i_in_valid <= 1'b0;
            end
        end
        burst_left--;
        @(negedge i_clk);
        i_in_valid    <= 1'b1;
        i_operation   <= op;
        i_table_index <= tidx;
        i_table_value <= tval;
        i_byte_offset <= off;
        i_pixel_zero  <= p0;
        i_pixel_one   <= p1;
        i_pixel_two   <= p2;
        i_pixel_three <= p3;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
    endtask

    // A table load. The fields a load does not use carry random values so
    // that the block is seen to ignore them.
    task automatic load_entry(input logic [INDEX_W-1:0] idx, input logic [7:0] value);
        push_transfer(OP_LOAD, idx, value, OFFSET_W'($urandom), 8'($urandom), 8'($urandom),
                      8'($urandom), 8'($urandom));
        if (int'(idx) < TABLE_SIZE) begin
            if (!entry_loaded[idx] && int'(idx) / PALETTE_ENTRIES == active_pal) begin
                usable_entries.push_back(int'(idx) % PALETTE_ENTRIES);
            end
            entry_loaded[idx] = 1'b1;
        end
    endtask

    task automatic convert_group(input logic [OFFSET_W-1:0] off,
                                 input logic [7:0] p0, input logic [7:0] p1,
                                 input logic [7:0] p2, input logic [7:0] p3);
        push_transfer(OP_CONVERT, INDEX_W'($urandom), 8'($urandom), off, p0, p1, p2, p3);
    endtask

    // Colours lean toward all-off and all-on so that plane bytes repeat and
    // the dirty filter often has nothing to send.
    function automatic logic [7:0] pick_colour();
        case ($urandom_range(0, 5))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [7:0] pick_pixel();
        return 8'(usable_entries[$urandom_range(0, usable_entries.size() - 1)]);
    endfunction

    // Most groups land on a handful of offsets so that a position is written
    // again and again; the rest spread over the whole plane, both ends too.
    function automatic logic [OFFSET_W-1:0] pick_offset();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 6) begin
            return OFFSET_W'($urandom_range(0, 15));
        end else if (roll == 6) begin
            return OFFSET_W'(BYTES_PER_PLANE - 1 - $urandom_range(0, 3));
        end
        return OFFSET_W'($urandom);
    endfunction

    // Waits until every expected plane write has come out, then lets the
    // pipeline settle, since a group that changed nothing may still be in it.
    task automatic drain_results();
        int waited;
        waited = 0;
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (outstanding != 0 && waited < DRAIN_LIMIT) begin
            @(negedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Palette changes happen only with the block idle. The list of usable
    // entries is rebuilt for the palette the block will actually use.
    task automatic select_palette(input logic [PAL_W-1:0] value);
        drain_results();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        palette_writes++;
        active_pal = (int'(value) >= PALETTES) ? PALETTES - 1 : int'(value);
        usable_entries.delete();
        for (int e = 0; e < PALETTE_ENTRIES; e++) begin
            if (entry_loaded[active_pal * PALETTE_ENTRIES + e]) begin
                usable_entries.push_back(e);
            end
        end
    endtask

    // Every phase loads the lowest and highest entry, so both values of each
    // pixel bit are always available, plus a few random entries.
    task automatic fill_palette();
        load_entry(INDEX_W'(active_pal * PALETTE_ENTRIES), pick_colour());
        load_entry(INDEX_W'(active_pal * PALETTE_ENTRIES + PALETTE_ENTRIES - 1), pick_colour());
        repeat (4) begin
            load_entry(INDEX_W'(active_pal * PALETTE_ENTRIES + $urandom_range(0, 255)),
                       pick_colour());
        end
    endtask

    // Random mix: mostly pixel groups, with loads into the palette in use,
    // into any palette, and past the end of the table, which is ignored.
    task automatic random_item();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 8) begin
            load_entry(INDEX_W'(active_pal * PALETTE_ENTRIES + $urandom_range(0, 255)),
                       pick_colour());
        end else if (roll < 11) begin
            load_entry(INDEX_W'($urandom_range(0, TABLE_SIZE - 1)), pick_colour());
        end else if (roll < 14) begin
            load_entry(INDEX_W'($urandom_range(TABLE_SIZE, (1 << INDEX_W) - 1)), 8'($urandom));
        end else begin
            convert_group(pick_offset(), pick_pixel(), pick_pixel(), pick_pixel(), pick_pixel());
        end
    endtask

    initial begin
        i_rst_n        = 1'b0;
        i_cfg_wr_en    = 1'b0;
        i_cfg_wr_data  = '0;
        i_in_valid     = 1'b0;
        i_operation    = OP_LOAD;
        i_table_index  = '0;
        i_table_value  = '0;
        i_byte_offset  = '0;
        i_pixel_zero   = '0;
        i_pixel_one    = '0;
        i_pixel_two    = '0;
        i_pixel_three  = '0;
        burst_left     = 0;
        palette_writes = 0;
        active_pal     = 0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // The block clears its plane shadow after reset and stalls the input
        // meanwhile; the first transfer simply waits for that to finish.
        select_palette(4'd0);

        // Directed part on palette zero. Entries give all-off, all-on and the
        // two half-lit colours; one load goes past the end of the table and one to
        // its very last byte.
        load_entry(INDEX_W'(0), 8'h00);
        load_entry(INDEX_W'(255), 8'hFF);
        load_entry(INDEX_W'(1), 8'h0F);
        load_entry(INDEX_W'(2), 8'hF0);
        load_entry(INDEX_W'((1 << INDEX_W) - 1), 8'hAA);
        load_entry(INDEX_W'(TABLE_SIZE - 1), 8'h5A);
        // All-off pixels match the cleared shadow, so nothing is written.
        convert_group(OFFSET_W'(0), 8'd0, 8'd0, 8'd0, 8'd0);
        // All-on changes all four planes; the same group again changes none.
        convert_group(OFFSET_W'(0), 8'd255, 8'd255, 8'd255, 8'd255);
        convert_group(OFFSET_W'(0), 8'd255, 8'd255, 8'd255, 8'd255);
        convert_group(OFFSET_W'(BYTES_PER_PLANE - 1), 8'd255, 8'd0, 8'd1, 8'd2);
        convert_group(OFFSET_W'(0), 8'd1, 8'd2, 8'd1, 8'd2);
        // These colours touch only the red and intensity planes, so the run
        // is two writes long and ends on plane zero.
        load_entry(INDEX_W'(3), 8'h81);
        load_entry(INDEX_W'(4), 8'h18);
        convert_group(OFFSET_W'(8191), 8'd3, 8'd4, 8'd3, 8'd4);
        // A load right before and right after a group that uses the entry.
        load_entry(INDEX_W'(5), 8'h33);
        convert_group(OFFSET_W'(1), 8'd5, 8'd5, 8'd5, 8'd5);
        load_entry(INDEX_W'(5), 8'hCC);
        convert_group(OFFSET_W'(1), 8'd5, 8'd5, 8'd5, 8'd5);
        convert_group(OFFSET_W'(1), 8'd5, 8'd5, 8'd5, 8'd5);
        convert_group(OFFSET_W'(8191), 8'd0, 8'd0, 8'd0, 8'd0);

        foreach (palette_plan[i]) begin
            select_palette(palette_plan[i]);
            fill_palette();
            repeat (RANDOM_PER_PHASE) random_item();
        end

        drain_results();
        if (outstanding != 0) begin
            $display("%0d expected plane writes never arrived", outstanding);
        end
        $display("Covered %0d table loads and %0d pixel groups over %0d palette settings,",
                 table_loads, pixel_groups, palette_writes);
        $display("with %0d plane writes checked under varying result stalls.", writes_checked);
        if (fail_count == 0 && outstanding == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // Far beyond the slowest correct run: the shadow clear, every group
    // causing four writes and every write waiting out the longest stall.
    initial begin
        #1_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/c2p_pkg.sv
hdl/c2p_front.sv
hdl/c2p_queue.sv
hdl/c2p_back.sv
hdl/chunky_to_planar_dirty_writer_core.sv
dv/chunky_to_planar_dirty_writer_checker.sv
dv/chunky_to_planar_dirty_writer_core_tb.sv
